// ----- hw/rtl/rmwq_pkg.sv -----
// Shared types and codes for the recursive mutex with waiter queue.
package rmwq_pkg;

  typedef enum logic [3:0] {
    ST_ACQUIRED   = 4'd0,
    ST_NESTED     = 4'd1,
    ST_QUEUED     = 4'd2,
    ST_STILL_HELD = 4'd3,
    ST_HANDED_OFF = 4'd4,
    ST_RELEASED   = 4'd5,
    ST_NOT_OWNER  = 4'd6,
    ST_QUEUE_FULL = 4'd7,
    ST_DEPTH_OVF  = 4'd8
  } status_t;

  localparam logic FUNC_LOCK   = 1'b0;
  localparam logic FUNC_UNLOCK = 1'b1;

  localparam int TASK_W  = 8;
  localparam int DEPTH_W = 16;

  typedef struct packed {
    logic              func;
    logic [TASK_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               owner_valid;
    logic [TASK_W-1:0]  owner_task;
    logic [DEPTH_W-1:0] hold_depth;
    logic               woken_valid;
    logic [TASK_W-1:0]  woken_task;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

// ----- hw/rtl/rmwq_ctrl.sv -----
// Request sequencer: accept, execute, present result.
module rmwq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output rmwq_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.execute = (state_r == S_EXEC);

endmodule

// ----- hw/rtl/rmwq_dp.sv -----
// Mutex state, waiter queue memory and result register.
module rmwq_dp #(
  parameter int MAX_WAITERS  = 16,
  parameter int TASK_ID_BITS = 8,
  parameter int DEPTH_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmwq_pkg::dp_cmd_t   cmd,
  input  rmwq_pkg::in_item_t  in_data,
  output rmwq_pkg::out_item_t out_data
);

  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W = $clog2(MAX_WAITERS + 1);
  localparam int TIN_W = (TASK_ID_BITS < rmwq_pkg::TASK_W) ? TASK_ID_BITS : rmwq_pkg::TASK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WAITERS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_WAITERS);

  logic [TASK_ID_BITS-1:0] mem [MAX_WAITERS];
  logic [TASK_ID_BITS-1:0] head_data_r;

  logic                    func_r;
  logic [TASK_ID_BITS-1:0] task_r;

  logic                    held_r, held_nxt;
  logic [TASK_ID_BITS-1:0] owner_r, owner_nxt;
  logic [DEPTH_BITS-1:0]   depth_r, depth_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [IDX_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    wr_en;

  rmwq_pkg::status_t   status;
  logic                woken;
  rmwq_pkg::out_item_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_data.func;
      task_r <= TASK_ID_BITS'(in_data.task_id[TIN_W-1:0]);
    end
  end

  always_comb begin
    held_nxt  = held_r;
    owner_nxt = owner_r;
    depth_nxt = depth_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    woken     = 1'b0;
    status    = rmwq_pkg::ST_NOT_OWNER;
    if (func_r == rmwq_pkg::FUNC_LOCK) begin
      if (!held_r) begin
        held_nxt  = 1'b1;
        owner_nxt = task_r;
        depth_nxt = DEPTH_BITS'(1);
        status    = rmwq_pkg::ST_ACQUIRED;
      end else if (owner_r == task_r) begin
        if (depth_r == {DEPTH_BITS{1'b1}}) begin
          status = rmwq_pkg::ST_DEPTH_OVF;
        end else begin
          depth_nxt = depth_r + DEPTH_BITS'(1);
          status    = rmwq_pkg::ST_NESTED;
        end
      end else if (count_r >= FULL_CNT) begin
        status = rmwq_pkg::ST_QUEUE_FULL;
      end else begin
        wr_en     = 1'b1;
        tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + IDX_W'(1);
        count_nxt = count_r + CNT_W'(1);
        status    = rmwq_pkg::ST_QUEUED;
      end
    end else begin
      if (!held_r || owner_r != task_r) begin
        status = rmwq_pkg::ST_NOT_OWNER;
      end else if (depth_r > DEPTH_BITS'(1)) begin
        depth_nxt = depth_r - DEPTH_BITS'(1);
        status    = rmwq_pkg::ST_STILL_HELD;
      end else if (count_r != '0) begin
        head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
        count_nxt = count_r - CNT_W'(1);
        owner_nxt = head_data_r;
        depth_nxt = DEPTH_BITS'(1);
        woken     = 1'b1;
        status    = rmwq_pkg::ST_HANDED_OFF;
      end else begin
        held_nxt  = 1'b0;
        owner_nxt = '0;
        depth_nxt = '0;
        status    = rmwq_pkg::ST_RELEASED;
      end
    end
  end

  always_comb begin
    res_nxt.status      = status;
    res_nxt.owner_valid = held_nxt;
    res_nxt.owner_task  = held_nxt ? rmwq_pkg::TASK_W'(owner_nxt) : '0;
    res_nxt.hold_depth  = held_nxt ? rmwq_pkg::DEPTH_W'(depth_nxt) : '0;
    res_nxt.woken_valid = woken;
    res_nxt.woken_task  = woken ? rmwq_pkg::TASK_W'(head_data_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      owner_r <= '0;
      depth_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.execute) begin
      held_r  <= held_nxt;
      owner_r <= owner_nxt;
      depth_r <= depth_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[tail_r] <= task_r;
    end
    head_data_r <= mem[head_r];
  end

  assign out_data = res_r;

endmodule

// ----- hw/rtl/recursive_mutex_with_wait_queue_top.sv -----
// Recursive mutex with FIFO hand-off to waiting tasks.
//
// Input channel (in_valid/in_stall/in_data): one lock or unlock request per
// transfer, naming the requesting task. Output channel (out_valid/out_stall/
// out_data): exactly one result per request, giving the status code, the
// owner and hold depth after the request, and the task woken by a hand-off.
//
// Each request is handled in turn: the transfer is taken, then the mutex state
// and the waiter queue are updated, then the result is presented.
// The waiter queue is a memory with a registered read port; its head entry is
// read ahead so the hand-off needs no separate read. A new request is taken
// only once the result of the last one has been transferred.
//
// After reset the mutex is free and the queue is empty; no clearing pass.
// While the receiver stalls, the result holds and in_stall stays high, so no
// new request is taken until the result transfer completes.
module recursive_mutex_with_wait_queue_top #(
  parameter int MAX_WAITERS  = 16,
  parameter int TASK_ID_BITS = 8,
  parameter int DEPTH_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmwq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmwq_pkg::out_item_t out_data
);

  rmwq_pkg::dp_cmd_t cmd;

  rmwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rmwq_dp #(
    .MAX_WAITERS  (MAX_WAITERS),
    .TASK_ID_BITS (TASK_ID_BITS),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- tb/recursive_mutex_with_wait_queue_top_test.sv -----
// Self-checking testbench for the recursive mutex with FIFO hand-off to waiting tasks.
module recursive_mutex_with_wait_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1425;
  localparam int HOLD_OFF_CYCLES = 200;

  class mutex_tracker;
    localparam int WAITER_SLOTS = 16;

    logic                         held = 1'b0;
    logic [rmwq_pkg::TASK_W-1:0]  owner = '0;
    logic [rmwq_pkg::DEPTH_W-1:0] depth = '0;
    logic [rmwq_pkg::TASK_W-1:0]  waiters[$];
    rmwq_pkg::out_item_t          awaited[$];
    int                           errors = 0;

    function int outstanding();
      return awaited.size();
    endfunction

    function void accept_request(rmwq_pkg::in_item_t req);
      rmwq_pkg::out_item_t r;
      r = '0;
      if (req.func == rmwq_pkg::FUNC_LOCK) begin
        if (!held) begin
          held = 1'b1;
          owner = req.task_id;
          depth = rmwq_pkg::DEPTH_W'(1);
          r.status = rmwq_pkg::ST_ACQUIRED;
        end else if (owner == req.task_id) begin
          if (depth == '1) begin
            r.status = rmwq_pkg::ST_DEPTH_OVF;
          end else begin
            depth++;
            r.status = rmwq_pkg::ST_NESTED;
          end
        end else if (waiters.size() >= WAITER_SLOTS) begin
          r.status = rmwq_pkg::ST_QUEUE_FULL;
        end else begin
          waiters.push_back(req.task_id);
          r.status = rmwq_pkg::ST_QUEUED;
        end
      end else begin
        if (!held || owner != req.task_id) begin
          r.status = rmwq_pkg::ST_NOT_OWNER;
        end else if (depth > rmwq_pkg::DEPTH_W'(1)) begin
          depth--;
          r.status = rmwq_pkg::ST_STILL_HELD;
        end else if (waiters.size() > 0) begin
          owner = waiters.pop_front();
          depth = rmwq_pkg::DEPTH_W'(1);
          r.woken_valid = 1'b1;
          r.woken_task = owner;
          r.status = rmwq_pkg::ST_HANDED_OFF;
        end else begin
          held = 1'b0;
          owner = '0;
          depth = '0;
          r.status = rmwq_pkg::ST_RELEASED;
        end
      end
      r.owner_valid = held;
      r.owner_task = held ? owner : '0;
      r.hold_depth = held ? depth : '0;
      awaited.push_back(r);
    endfunction

    function void check_response(rmwq_pkg::out_item_t got);
      rmwq_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing awaited: status %0d", got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.owner_valid !== want.owner_valid) begin
        $error("owner_valid: expected %0d, got %0d", want.owner_valid, got.owner_valid);
        errors++;
      end
      if (got.owner_task !== want.owner_task) begin
        $error("owner_task: expected %0d, got %0d", want.owner_task, got.owner_task);
        errors++;
      end
      if (got.hold_depth !== want.hold_depth) begin
        $error("hold_depth: expected %0d, got %0d", want.hold_depth, got.hold_depth);
        errors++;
      end
      if (got.woken_valid !== want.woken_valid) begin
        $error("woken_valid: expected %0d, got %0d", want.woken_valid, got.woken_valid);
        errors++;
      end
      if (got.woken_task !== want.woken_task) begin
        $error("woken_task: expected %0d, got %0d", want.woken_task, got.woken_task);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rmwq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rmwq_pkg::out_item_t out_data;

  logic quiet = 1'b0;
  logic hold_off_req = 1'b0;

  mutex_tracker sb = new();

  recursive_mutex_with_wait_queue_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(input logic fn, input logic [rmwq_pkg::TASK_W-1:0] id);
    rmwq_pkg::in_item_t req;
    req.func = fn;
    req.task_id = id;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    sb.accept_request(req);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_response(out_data);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        if (!quiet) begin
          n = $urandom_range(1, 24);
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [rmwq_pkg::TASK_W-1:0] pool[6];
    logic [rmwq_pkg::TASK_W-1:0] id;
    logic [rmwq_pkg::TASK_W-1:0] deep_owner;
    logic                        fn;
    int                          pct_other;
    int                          roll;
    int                          n;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_request(rmwq_pkg::FUNC_UNLOCK, 8'h00);
    send_request(rmwq_pkg::FUNC_LOCK, 8'h00);
    send_request(rmwq_pkg::FUNC_LOCK, 8'h00);
    send_request(rmwq_pkg::FUNC_UNLOCK, 8'hFF);
    send_request(rmwq_pkg::FUNC_UNLOCK, 8'h00);
    send_request(rmwq_pkg::FUNC_LOCK, 8'hFF);
    send_request(rmwq_pkg::FUNC_LOCK, 8'hFF);
    for (int k = 0; k < 14; k++) begin
      send_request(rmwq_pkg::FUNC_LOCK, 8'(k * 17 + 1));
    end
    send_request(rmwq_pkg::FUNC_LOCK, 8'h5A);
    send_request(rmwq_pkg::FUNC_LOCK, 8'h00);
    send_request(rmwq_pkg::FUNC_UNLOCK, 8'h00);
    send_request(rmwq_pkg::FUNC_UNLOCK, 8'h00);
    send_request(rmwq_pkg::FUNC_UNLOCK, 8'hFF);

    // random: mostly owner traffic plus contention from a small task pool
    pct_other = 5;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: pct_other = 5;
          1: pct_other = 15;
          default: pct_other = 31;
        endcase
        foreach (pool[j]) pool[j] = 8'($urandom_range(0, 255));
      end
      if (i == 400) hold_off_req = 1'b1;
      if (i == RANDOM_ITEMS - 150) quiet = 1'b1;

      id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : pool[$urandom_range(0, 5)];
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        fn = sb.held ? rmwq_pkg::FUNC_UNLOCK : rmwq_pkg::FUNC_LOCK;
        if (sb.held) id = sb.owner;
      end else if (roll < 64) begin
        fn = rmwq_pkg::FUNC_LOCK;
        if (sb.held) id = sb.owner;
      end else if (roll < 64 + pct_other) begin
        fn = rmwq_pkg::FUNC_LOCK;
      end else begin
        fn = 1'($urandom_range(0, 1));
      end
      send_request(fn, id);

      if (!quiet && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
    end

    // nest deeper, then unwind past the added levels by one more
    if (!sb.held) send_request(rmwq_pkg::FUNC_LOCK, 8'hC3);
    deep_owner = sb.owner;
    repeat (8) send_request(rmwq_pkg::FUNC_LOCK, deep_owner);
    repeat (9) send_request(rmwq_pkg::FUNC_UNLOCK, deep_owner);

    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- recursive_mutex_with_wait_queue_top.f -----
hw/rtl/rmwq_pkg.sv
hw/rtl/rmwq_ctrl.sv
hw/rtl/rmwq_dp.sv
hw/rtl/recursive_mutex_with_wait_queue_top.sv
tb/recursive_mutex_with_wait_queue_top_test.sv
